// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dpnm_pkg.sv
package dpnm_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int SUM_BITS       = PIXEL_BITS + 3;
  localparam int CNT_BITS       = 4;
  localparam int CFG_BITS       = 13;
  localparam int CFG_INDEX_BITS = 8;
  localparam int ROW_BITS       = CFG_BITS + 1;
  localparam int MAX_WIDTH_DEF  = 4096;

  localparam logic [CFG_BITS-1:0] FRAME_DIM_RESET = CFG_BITS'(1024);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         pixel_good;
    logic                         flush;
  } pix_in_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] clean_value;
    logic                         replaced;
    logic                         no_good_neighbour;
    logic                         frame_last;
  } pix_out_t;

  // One stored sample, good flag on top.
  typedef struct packed {
    logic                         good;
    logic signed [PIXEL_BITS-1:0] value;
  } entry_t;

  // Line store word: two rows above the incoming one at a given column.
  typedef struct packed {
    entry_t upper;
    entry_t lower;
  } pair_t;

  typedef struct packed {
    entry_t top;
    entry_t mid;
    entry_t bot;
  } column_t;

  // Which neighbour rows and columns lie inside the image.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

  typedef struct packed {
    entry_t                     centre;
    logic signed [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0]        count;
  } nbr_t;

endpackage

// File: rtl/dpnm_line_store.sv
module dpnm_line_store #(
  parameter int MAX_WIDTH = dpnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  dpnm_pkg::pair_t              wr_data,
  output dpnm_pkg::pair_t              rd_data
);

  dpnm_pkg::pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/dpnm_window.sv
module dpnm_window (
  input  logic              clk,
  input  logic              load,
  input  dpnm_pkg::column_t col,
  input  dpnm_pkg::mask_t   mask,
  output dpnm_pkg::nbr_t    nbr
);

  localparam int PIXEL_BITS = dpnm_pkg::PIXEL_BITS;
  localparam int SUM_BITS   = dpnm_pkg::SUM_BITS;
  localparam int CNT_BITS   = dpnm_pkg::CNT_BITS;

  // prev1 holds the centre column, prev2 the one to its left
  dpnm_pkg::column_t prev1;
  dpnm_pkg::column_t prev2;

  dpnm_pkg::entry_t           ent [8];
  logic [7:0]                 sel;
  logic signed [SUM_BITS-1:0] sum;
  logic [CNT_BITS-1:0]        count;

  always_comb begin
    ent[0] = prev2.top;  sel[0] = mask.left & mask.top;
    ent[1] = prev2.mid;  sel[1] = mask.left;
    ent[2] = prev2.bot;  sel[2] = mask.left & mask.bottom;
    ent[3] = prev1.top;  sel[3] = mask.top;
    ent[4] = prev1.bot;  sel[4] = mask.bottom;
    ent[5] = col.top;    sel[5] = mask.right & mask.top;
    ent[6] = col.mid;    sel[6] = mask.right;
    ent[7] = col.bot;    sel[7] = mask.right & mask.bottom;
  end

  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < 8; i++) begin
      if (sel[i] && ent[i].good) begin
        sum   = sum + {{(SUM_BITS-PIXEL_BITS){ent[i].value[PIXEL_BITS-1]}}, ent[i].value};
        count = count + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nbr.centre <= prev1.mid;
      nbr.sum    <= sum;
      nbr.count  <= count;
      prev2      <= prev1;
      prev1      <= col;
    end
  end

endmodule

// File: rtl/dpnm_divider.sv
module dpnm_divider (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [dpnm_pkg::SUM_BITS-1:0]  dividend,
  input  logic [dpnm_pkg::CNT_BITS-1:0]         divisor,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [dpnm_pkg::PIXEL_BITS-1:0] quotient
);

  localparam int PIXEL_BITS = dpnm_pkg::PIXEL_BITS;
  localparam int SUM_BITS   = dpnm_pkg::SUM_BITS;
  localparam int CNT_BITS   = dpnm_pkg::CNT_BITS;
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  logic [SUM_BITS-1:0]  shreg;
  logic [CNT_BITS-1:0]  rem;
  logic [CNT_BITS-1:0]  dvs;
  logic                 neg;
  logic [STEP_BITS-1:0] steps;

  logic [SUM_BITS-1:0]   mag_in;
  logic [CNT_BITS:0]     trial;
  logic [CNT_BITS:0]     diff;
  logic                  fits;
  logic [PIXEL_BITS-1:0] q_lo;

  // Restoring division on the magnitude, one quotient bit per cycle
  assign mag_in = dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;
  assign trial  = {rem, shreg[SUM_BITS-1]};
  assign fits   = trial >= {1'b0, dvs};
  assign diff   = trial - {1'b0, dvs};

  // Truncate toward zero: negate the magnitude quotient afterwards
  assign q_lo     = shreg[PIXEL_BITS-1:0];
  assign quotient = neg ? (PIXEL_BITS'(0) - q_lo) : q_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + STEP_BITS'(1);
        if (steps == STEP_BITS'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag_in;
      rem   <= '0;
      dvs   <= divisor;
      neg   <= dividend[SUM_BITS-1];
    end else if (busy) begin
      shreg <= {shreg[SUM_BITS-2:0], fits};
      rem   <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

endmodule

// File: rtl/dead_pixel_neighbor_mean_fill.sv
// Each result leaves frame_width + 1 items after its pixel; frame_width + 1 flush items
// drain the end of a frame. Only idle takes items; a flush in the frame is dropped, others
// pass load and sum, where one with no result ends; a good pixel or a dead one with no good
// neighbour emits, other dead pixels are averaged in the bit-serial divider, and emit waits
// while the result register is held. Synchronous reset clears positions, sets both frame
// registers to 1024; line store and window need no clearing, out-of-image taps are masked.
`include "assert_macros.svh"

module dead_pixel_neighbor_mean_fill #(
  parameter int MAX_WIDTH = dpnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pix_valid,
  output logic                                  pix_ready,
  input  dpnm_pkg::pix_in_t                     pix,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output dpnm_pkg::pix_out_t                    res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dpnm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dpnm_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
  localparam int ROW_BITS   = dpnm_pkg::ROW_BITS;
  localparam int CFG_BITS   = dpnm_pkg::CFG_BITS;
  localparam int PIXEL_BITS = dpnm_pkg::PIXEL_BITS;

  logic [CFG_BITS-1:0]   frame_width;
  logic [CFG_BITS-1:0]   frame_height;
  logic [WIDTH_BITS-1:0] eff_w;
  logic [ROW_BITS-1:0]   eff_h;

  logic [COL_BITS-1:0]   in_col;
  logic [ROW_BITS-1:0]   in_row;
  logic [WIDTH_BITS-1:0] col_inc;

  dpnm_pkg::state_t state;
  dpnm_pkg::state_t state_next;

  logic cfg_fire;
  logic cfg_hit;
  logic pix_fire;
  logic in_body;
  logic skip;
  logic take;
  logic col0;

  dpnm_pkg::mask_t  mask_now;
  dpnm_pkg::mask_t  mask;
  logic             has_res_now;
  logic             has_res;
  logic             last_now;
  logic             last;
  dpnm_pkg::entry_t item;
  logic [COL_BITS-1:0] item_col;

  dpnm_pkg::pair_t   rd_data;
  dpnm_pkg::pair_t   wr_data;
  dpnm_pkg::column_t new_col;
  dpnm_pkg::nbr_t    nbr;

  logic mem_rd_en;
  logic mem_wr_en;
  logic win_load;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic signed [PIXEL_BITS-1:0] quotient;

  logic               pend_from_sum;
  logic               pend_from_div;
  logic               res_load;
  dpnm_pkg::pix_out_t pend;

  // Effective frame size
  always_comb begin
    if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WIDTH_BITS'(MAX_WIDTH);
    end else if (frame_width == '0) begin
      eff_w = WIDTH_BITS'(1);
    end else begin
      eff_w = WIDTH_BITS'(frame_width);
    end
  end

  assign eff_h = (frame_height == '0) ? ROW_BITS'(1) : ROW_BITS'(frame_height);

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == dpnm_pkg::REG_FRAME_WIDTH ||
                                  cfg_index == dpnm_pkg::REG_FRAME_HEIGHT);

  assign pix_fire  = pix_valid && pix_ready;
  assign in_body   = in_row < eff_h;
  // drop a flush that arrives inside the frame body
  assign skip      = in_body && pix.flush;
  assign take      = pix_fire && !skip;
  assign mem_rd_en = take;
  assign col_inc   = WIDTH_BITS'(in_col) + WIDTH_BITS'(1);
  assign col0      = in_col == '0;

  // A column-zero item emits the last pixel of the row two above, else the pixel
  // one row up and one column left.
  always_comb begin
    mask_now.top    = col0 ? (in_row >= ROW_BITS'(3)) : (in_row >= ROW_BITS'(2));
    mask_now.bottom = col0 ? (in_row <= eff_h) : (in_row < eff_h);
    mask_now.left   = col0 ? (eff_w >= WIDTH_BITS'(2)) : (in_col >= COL_BITS'(2));
    mask_now.right  = !col0;
    has_res_now     = col0 ? (in_row >= ROW_BITS'(2)) : (in_row >= ROW_BITS'(1));
    last_now        = col0 && (in_row == eff_h + ROW_BITS'(1));
  end

  always_comb begin
    new_col.top   = rd_data.upper;
    new_col.mid   = rd_data.lower;
    new_col.bot   = item;
    wr_data.upper = rd_data.lower;
    wr_data.lower = item;
  end

  dpnm_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(in_col),
    .wr_en  (mem_wr_en),
    .wr_addr(item_col),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  dpnm_window u_window (
    .clk (clk),
    .load(win_load),
    .col (new_col),
    .mask(mask),
    .nbr (nbr)
  );

  dpnm_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(nbr.sum),
    .divisor (nbr.count),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dpnm_pkg::ST_IDLE: begin
        if (take) state_next = dpnm_pkg::ST_LOAD;
      end
      dpnm_pkg::ST_LOAD: begin
        state_next = dpnm_pkg::ST_SUM;
      end
      dpnm_pkg::ST_SUM: begin
        if (!has_res) begin
          state_next = dpnm_pkg::ST_IDLE;
        end else if (nbr.centre.good || nbr.count == '0) begin
          state_next = dpnm_pkg::ST_EMIT;
        end else begin
          state_next = dpnm_pkg::ST_DIV;
        end
      end
      dpnm_pkg::ST_DIV: begin
        if (div_done) state_next = dpnm_pkg::ST_EMIT;
      end
      dpnm_pkg::ST_EMIT: begin
        if (!res_valid || res_ready) state_next = dpnm_pkg::ST_IDLE;
      end
      default: begin
        state_next = dpnm_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    pix_ready     = 1'b0;
    mem_wr_en     = 1'b0;
    win_load      = 1'b0;
    div_start     = 1'b0;
    pend_from_sum = 1'b0;
    pend_from_div = 1'b0;
    res_load      = 1'b0;
    case (state)
      dpnm_pkg::ST_IDLE: begin
        pix_ready = 1'b1;
      end
      dpnm_pkg::ST_LOAD: begin
        mem_wr_en = 1'b1;
        win_load  = 1'b1;
      end
      dpnm_pkg::ST_SUM: begin
        if (has_res) begin
          if (nbr.centre.good || nbr.count == '0) begin
            pend_from_sum = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      dpnm_pkg::ST_DIV: begin
        pend_from_div = div_done;
      end
      dpnm_pkg::ST_EMIT: begin
        res_load = !res_valid || res_ready;
      end
      default: begin
        pix_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dpnm_pkg::ST_IDLE;
      frame_width  <= dpnm_pkg::FRAME_DIM_RESET;
      frame_height <= dpnm_pkg::FRAME_DIM_RESET;
      in_col       <= '0;
      in_row       <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_fire && cfg_index == dpnm_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end
      if (cfg_fire && cfg_index == dpnm_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end

      // restart the stream on a register write or after the frame's last result
      if (cfg_hit) begin
        in_col <= '0;
        in_row <= '0;
      end else if (take) begin
        if (last_now) begin
          in_col <= '0;
          in_row <= '0;
        end else if (col_inc >= eff_w) begin
          in_col <= '0;
          in_row <= in_row + ROW_BITS'(1);
        end else begin
          in_col <= COL_BITS'(col_inc);
        end
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.value <= pix.pixel_value;
      item.good  <= pix.pixel_good;
      item_col   <= in_col;
      mask       <= mask_now;
      has_res    <= has_res_now;
      last       <= last_now;
    end

    if (pend_from_sum) begin
      pend.clean_value       <= nbr.centre.good ? nbr.centre.value : '0;
      pend.replaced          <= !nbr.centre.good;
      pend.no_good_neighbour <= !nbr.centre.good;
      pend.frame_last        <= last;
    end else if (pend_from_div) begin
      pend.clean_value       <= quotient;
      pend.replaced          <= 1'b1;
      pend.no_good_neighbour <= 1'b0;
      pend.frame_last        <= last;
    end

    if (res_load) begin
      res <= pend;
    end
  end

  `ASSERT_IMPLIES(a_col_below_width, clk, rst, 1'b1, WIDTH_BITS'(in_col) < eff_w, "bad column")
  `ASSERT_IMPLIES(a_div_owned, clk, rst, div_busy || div_done, state == dpnm_pkg::ST_DIV, "stray div")
  `ASSERT_NEXT(a_write_follows_read, clk, rst, mem_rd_en, mem_wr_en, "read not written back")
  `ASSERT_IMPLIES(a_empty_is_zero, clk, rst, res_valid && res.no_good_neighbour, res.replaced && res.clean_value == '0, "not zero")

endmodule
